[sv/vbe_pkg.sv]
`default_nettype none

package vbe_pkg;

    // Config register indexes
    localparam logic [2:0] REG_VOL_WIDTH    = 3'd0;
    localparam logic [2:0] REG_VOL_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_VOL_DEPTH    = 3'd2;
    localparam logic [2:0] REG_TARGET_LABEL = 3'd3;
    localparam logic [2:0] REG_NULL_LABEL   = 3'd4;

    localparam int DEPTH_LIMIT = 4096;
    localparam int DIM_BITS    = 13;   // depth register and virtual z counter
    localparam int POS_Z_BITS  = 12;

    typedef logic [2:0] t_cfg_idx;

endpackage

`default_nettype wire

[sv/voxel_boundary_extract_3d.sv]
// Boundary voxel extractor for a labelled 3-D volume (26-neighbor test).
// Slave channel: one transfer per item; tuser = action (0 voxel, 1 flush),
//   tdata = label. Voxels come in raster order, x fastest, then y, then z.
// Master channel: one transfer per reported voxel, in raster order.
//   tdata = pos_x, pos_y, pos_z, label_out; tuser = is_boundary, is_selected;
//   tlast marks the final voxel of the volume.
// Config channel: index/data write, ready while no step is in flight; a write
//   to index 0 to 4 restarts the stream. s_tready stays low while a write is
//   offered and after it until the derived plane/total/lag sizes settle.
// A voxel is reported once the voxel one plane plus one row plus one voxel
// later has been accepted; after the whole volume, each item (voxel or flush)
// releases one more result from an internal drain step, which follows that item
// once the master side lets the pipeline advance and holds s_tready low until it runs.
// Throughput: one voxel per clock inside the volume while the master side keeps up;
// after it, each item waits for the drain step of the item before it.
// From the transfer that completes a voxel's window to its result on the master
// side, the data passes three registers in order: memory read, window shift,
// output register. A drain result takes the same path, starting at the drain step
// that follows its item. Reset clears counters and valids and loads register
// defaults; the memories are not cleared. A stalled master side freezes the
// pipeline and drops s_tready until the output register frees up.
`default_nettype none

module voxel_boundary_extract_3d #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128,
    parameter int LABEL_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] label_in
    input  wire logic        i_s_tuser,   // [0] action
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [63:0]      o_m_tdata,   // [6:0] pos_x, [13:7] pos_y, [25:14] pos_z,
                                          // [57:26] label_out, [63:58] zero
    output logic [1:0]       o_m_tuser,   // [0] is_boundary, [1] is_selected
    output logic             o_m_tlast
);

    localparam int LB = LABEL_BITS;
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int DB = vbe_pkg::DIM_BITS;
    localparam int ZB = vbe_pkg::POS_Z_BITS;
    localparam int PW = WW + HW;
    localparam int CW = PW + DB + 1;
    localparam int RST_W = (MAX_WIDTH < 128) ? MAX_WIDTH : 128;
    localparam int RST_H = (MAX_HEIGHT < 128) ? MAX_HEIGHT : 128;
    localparam int RST_PLANE = RST_W * RST_H;
    localparam int RST_TOTAL = RST_PLANE * 128;
    localparam int RST_LAG = RST_PLANE + RST_W + 1;

    function automatic logic [WW-1:0] clamp_w(input logic [7:0] v);
        if (v == 8'd0) return WW'(1);
        if (int'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
        return WW'(v);
    endfunction

    function automatic logic [HW-1:0] clamp_h(input logic [7:0] v);
        if (v == 8'd0) return HW'(1);
        if (int'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
        return HW'(v);
    endfunction

    function automatic logic [DB-1:0] clamp_d(input logic [12:0] v);
        if (v == 13'd0) return DB'(1);
        if (int'(v) > vbe_pkg::DEPTH_LIMIT) return DB'(vbe_pkg::DEPTH_LIMIT);
        return DB'(v);
    endfunction

    // Configuration and derived sizes
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [DB-1:0] r_d;
    logic [LB-1:0] r_target, r_null;
    logic [PW-1:0] r_plane;
    logic [CW-1:0] r_total, r_lag;
    logic [1:0]    r_cfg_wait;        // cycles until derived sizes are valid

    // Stream counters: accepted/reported (item view) and step position
    logic [CW-1:0] r_in, r_out, r_v;
    logic [XW-1:0] r_vx, r_cx;
    logic [YW-1:0] r_vy, r_cy;
    logic [DB-1:0] r_vz;
    logic [ZB-1:0] r_cz;

    // Memories: plane store holds z-1/z-2 per (x,y), row store holds rows y-1/y-2
    logic [2*LB-1:0] mem_a [2**(XW+YW)];
    logic [6*LB-1:0] mem_b [2**XW];
    logic [2*LB-1:0] r_a_rd, r_fa_data;
    logic [6*LB-1:0] r_b_rd, r_fb_data;
    logic            r_p1_fa, r_p1_fb;

    // Pipeline
    logic          r_p1_valid, r_p1_emit;
    logic [XW-1:0] r_p1_x, r_p1_cx, r_p2_cx;
    logic [YW-1:0] r_p1_y, r_p1_cy, r_p2_cy;
    logic [ZB-1:0] r_p1_cz, r_p2_cz;
    logic [LB-1:0] r_p1_label;
    logic          r_p2_valid;
    logic [LB-1:0] r_win [3][3][3];   // [dx][dy][dz], index 0 is newest

    logic        r_m_valid, r_m_last;
    logic [63:0] r_m_data;
    logic [1:0]  r_m_user;

    logic          adv, flush_ph, g_go, acc, rs, wr, emit_m, step, s_emit, p1_wr;
    logic          cfg_wr;
    logic [CW-1:0] in0, out0, in1;
    logic [CW-1:0] b_v;
    logic [XW-1:0] b_vx, b_cx, n_vx, n_cx;
    logic [YW-1:0] b_vy, b_cy, n_vy, n_cy;
    logic [DB-1:0] b_vz, n_vz;
    logic [ZB-1:0] b_cz, n_cz;
    logic [LB-1:0] s_label;
    logic [2*LB-1:0] a_rd, a_wdata;
    logic [6*LB-1:0] b_rd, b_wdata;
    logic [LB-1:0] col [3][3];        // [dy][dz]
    logic [LB-1:0] ctr;
    logic          diff, edge_hit, bnd, sel, lastv;

    // Item bookkeeping, mirrors the per-item counters
    always_comb begin
        adv      = !r_m_valid || i_m_tready;
        flush_ph = r_in >= r_total;
        g_go     = flush_ph && (r_v < r_out + r_lag);
        // writes wait until no step is left in the pipeline
        o_cfg_ready = !g_go && !r_p1_valid && !r_p2_valid;
        cfg_wr   = i_cfg_valid && o_cfg_ready;
        o_s_tready = adv && !g_go && !i_cfg_valid && (r_cfg_wait == 2'd0);
        acc      = i_s_tvalid && o_s_tready;
        rs       = flush_ph && (r_out >= r_total);
        in0      = rs ? '0 : r_in;
        out0     = rs ? '0 : r_out;
        wr       = !i_s_tuser && (in0 < r_total);
        in1      = in0 + CW'(wr);
        emit_m   = (out0 < r_total) && ((in1 >= r_total) || (in1 - out0 > r_lag));
        step     = (acc && wr) || (adv && g_go);
        p1_wr    = r_p1_valid && adv;
    end

    // Step position and center coordinates
    always_comb begin
        b_v  = (acc && rs) ? '0 : r_v;
        b_vx = (acc && rs) ? '0 : r_vx;
        b_vy = (acc && rs) ? '0 : r_vy;
        b_vz = (acc && rs) ? '0 : r_vz;
        b_cx = (acc && rs) ? '0 : r_cx;
        b_cy = (acc && rs) ? '0 : r_cy;
        b_cz = (acc && rs) ? '0 : r_cz;
        s_emit  = b_v >= r_lag;
        s_label = acc ? LB'(i_s_tdata) : '0;   // drain steps feed filler
        n_vx = b_vx + XW'(1);
        n_vy = b_vy;
        n_vz = b_vz;
        if (WW'(b_vx) == r_w - WW'(1)) begin
            n_vx = '0;
            n_vy = b_vy + YW'(1);
            if (HW'(b_vy) == r_h - HW'(1)) begin
                n_vy = '0;
                n_vz = b_vz + DB'(1);
            end
        end
        n_cx = b_cx + XW'(1);
        n_cy = b_cy;
        n_cz = b_cz;
        if (WW'(b_cx) == r_w - WW'(1)) begin
            n_cx = '0;
            n_cy = b_cy + YW'(1);
            if (HW'(b_cy) == r_h - HW'(1)) begin
                n_cy = '0;
                n_cz = b_cz + ZB'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w      <= WW'(RST_W);
            r_h      <= HW'(RST_H);
            r_d      <= DB'(128);
            r_target <= LB'(1);
            r_null   <= '0;
            r_plane  <= PW'(RST_PLANE);
            r_total  <= CW'(RST_TOTAL);
            r_lag    <= CW'(RST_LAG);
            r_cfg_wait <= '0;
            r_in  <= '0;
            r_out <= '0;
            r_v   <= '0;
            r_vx  <= '0;
            r_vy  <= '0;
            r_vz  <= '0;
            r_cx  <= '0;
            r_cy  <= '0;
            r_cz  <= '0;
        end else begin
            r_plane <= PW'(r_w * r_h);
            r_total <= CW'(r_plane * r_d);
            r_lag   <= CW'(r_plane) + CW'(r_w) + CW'(1);
            if (cfg_wr) begin
                r_cfg_wait <= 2'd2;
                unique case (i_cfg_index)
                    vbe_pkg::REG_VOL_WIDTH:    r_w <= clamp_w(i_cfg_data[7:0]);
                    vbe_pkg::REG_VOL_HEIGHT:   r_h <= clamp_h(i_cfg_data[7:0]);
                    vbe_pkg::REG_VOL_DEPTH:    r_d <= clamp_d(i_cfg_data[12:0]);
                    vbe_pkg::REG_TARGET_LABEL: r_target <= LB'(i_cfg_data);
                    vbe_pkg::REG_NULL_LABEL:   r_null <= LB'(i_cfg_data);
                    default: ;
                endcase
                if (i_cfg_index <= vbe_pkg::REG_NULL_LABEL) begin
                    r_in  <= '0;
                    r_out <= '0;
                    r_v   <= '0;
                    r_vx  <= '0;
                    r_vy  <= '0;
                    r_vz  <= '0;
                    r_cx  <= '0;
                    r_cy  <= '0;
                    r_cz  <= '0;
                end
            end else begin
                if (r_cfg_wait != 2'd0) begin
                    r_cfg_wait <= r_cfg_wait - 2'd1;
                end
                if (acc) begin
                    r_in  <= in1;
                    r_out <= out0 + CW'(emit_m);
                end
                if (step) begin
                    r_v  <= b_v + CW'(1);
                    r_vx <= n_vx;
                    r_vy <= n_vy;
                    r_vz <= n_vz;
                    if (s_emit) begin
                        r_cx <= n_cx;
                        r_cy <= n_cy;
                        r_cz <= n_cz;
                    end else begin
                        r_cx <= b_cx;
                        r_cy <= b_cy;
                        r_cz <= b_cz;
                    end
                end else if (acc && rs) begin
                    // idle flush after a finished volume: restart step position
                    r_v  <= '0;
                    r_vx <= '0;
                    r_vy <= '0;
                    r_vz <= '0;
                    r_cx <= '0;
                    r_cy <= '0;
                    r_cz <= '0;
                end
            end
        end
    end

    // Read side, issued with the step
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_a_rd <= mem_a[{b_vy, b_vx}];
            r_b_rd <= mem_b[b_vx];
        end
    end

    // Write back from stage 1 once the pipeline advances
    always_ff @(posedge i_clk) begin
        if (p1_wr) begin
            mem_a[{r_p1_y, r_p1_x}] <= a_wdata;
            mem_b[r_p1_x] <= b_wdata;
        end
    end

    // Same entry written while being read: take the written word
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_p1_fa   <= p1_wr && ({r_p1_y, r_p1_x} == {b_vy, b_vx});
            r_p1_fb   <= p1_wr && (r_p1_x == b_vx);
            r_fa_data <= a_wdata;
            r_fb_data <= b_wdata;
            r_p1_x     <= b_vx;
            r_p1_y     <= b_vy;
            r_p1_label <= s_label;
            r_p1_emit  <= s_emit;
            r_p1_cx    <= b_cx;
            r_p1_cy    <= b_cy;
            r_p1_cz    <= b_cz;
        end
    end

    always_comb begin
        a_rd = r_p1_fa ? r_fa_data : r_a_rd;
        b_rd = r_p1_fb ? r_fb_data : r_b_rd;
        col[0][0] = r_p1_label;
        col[0][1] = a_rd[LB-1:0];
        col[0][2] = a_rd[2*LB-1:LB];
        for (int k = 0; k < 3; k++) begin
            col[1][k] = b_rd[k*LB +: LB];
            col[2][k] = b_rd[(3+k)*LB +: LB];
        end
        a_wdata = {a_rd[LB-1:0], r_p1_label};
        b_wdata = {b_rd[3*LB-1:0], col[0][2], col[0][1], col[0][0]};
    end

    // Window shift and stage valids
    always_ff @(posedge i_clk) begin
        if (p1_wr) begin
            for (int dy = 0; dy < 3; dy++) begin
                for (int dz = 0; dz < 3; dz++) begin
                    r_win[2][dy][dz] <= r_win[1][dy][dz];
                    r_win[1][dy][dz] <= r_win[0][dy][dz];
                    r_win[0][dy][dz] <= col[dy][dz];
                end
            end
            r_p2_cx <= r_p1_cx;
            r_p2_cy <= r_p1_cy;
            r_p2_cz <= r_p1_cz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_m_valid  <= 1'b0;
        end else if (adv) begin
            r_p1_valid <= step;
            r_p2_valid <= r_p1_valid && r_p1_emit;
            r_m_valid  <= r_p2_valid;
        end
    end

    // Neighbor test: inside the volume all 26 neighbors are real data
    always_comb begin
        ctr  = r_win[1][1][1];
        diff = 1'b0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_win[i][j][k] != ctr) diff = 1'b1;
                end
            end
        end
        edge_hit = (r_p2_cx == '0) || (WW'(r_p2_cx) == r_w - WW'(1)) ||
                   (r_p2_cy == '0) || (HW'(r_p2_cy) == r_h - HW'(1)) ||
                   (r_p2_cz == '0) || (DB'(r_p2_cz) == r_d - DB'(1));
        lastv = (WW'(r_p2_cx) == r_w - WW'(1)) && (HW'(r_p2_cy) == r_h - HW'(1)) &&
                (DB'(r_p2_cz) == r_d - DB'(1));
        bnd = (ctr != r_null) && (edge_hit || diff);
        sel = bnd && (ctr == r_target);
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_p2_valid) begin
            r_m_data <= {6'd0, 32'(ctr), 12'(r_p2_cz), 7'(r_p2_cy), 7'(r_p2_cx)};
            r_m_user <= {sel, bnd};
            r_m_last <= lastv;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

    a_sel_implies_bnd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser[0] || !o_m_tuser[1]))
        else $error("selected voxel not on boundary");

    a_out_le_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out <= r_in)
        else $error("more voxels reported than accepted");

    a_in_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(i_cfg_valid) && !$past(i_cfg_valid, 2)
            && !$past(i_cfg_valid, 3) |-> r_in <= r_total)
        else $error("accepted count beyond volume");

    a_drain_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        g_go |-> !o_s_tready)
        else $error("input taken during drain step");

endmodule

`default_nettype wire

[tb/boundary_checker.sv]
`timescale 1ns / 1ps

module boundary_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,
    input  wire logic        i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [63:0] i_m_tdata,
    input  wire logic [1:0]  i_m_tuser,
    input  wire logic        i_m_tlast,
    output int               o_errors,
    output int               o_pending,
    output int               o_checked
);

    typedef struct packed {
        logic [6:0]  x;
        logic [6:0]  y;
        logic [11:0] z;
        logic [31:0] lbl;
        logic        bnd;
        logic        sel;
        logic        last;
    } t_voxel_rpt;

    t_voxel_rpt  rpt_q[$];
    logic [31:0] vox_labels[int];
    logic [7:0]  width_reg, height_reg;
    logic [12:0] depth_reg;
    logic [31:0] target_reg, null_reg;
    int          in_pos, out_pos;
    int          errors, checked, pend;

    assign o_errors  = errors;
    assign o_pending = pend;
    assign o_checked = checked;

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the window model by one accepted item, queue any report it releases
    task automatic advance_window(logic flush, logic [31:0] lbl);
        int w, h, d, plane, total, lag, x, y, z, nx, ny, nz;
        bit bnd;
        logic [31:0] cur;
        t_voxel_rpt r;
        w = clamp_dim(width_reg, 128);
        h = clamp_dim(height_reg, 128);
        d = clamp_dim(depth_reg, vbe_pkg::DEPTH_LIMIT);
        plane = w * h;
        total = plane * d;
        lag = plane + w + 1;
        if (in_pos >= total && out_pos >= total) begin
            in_pos = 0;
            out_pos = 0;
        end
        if (!flush && in_pos < total) begin
            vox_labels[in_pos] = lbl;
            in_pos++;
        end
        if (out_pos >= total) return;
        if (in_pos < total && in_pos - out_pos <= lag) return;
        x = out_pos % w;
        y = (out_pos / w) % h;
        z = out_pos / plane;
        cur = vox_labels[out_pos];
        bnd = 0;
        if (cur != null_reg) begin
            for (int dz = -1; dz <= 1; dz++)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++) begin
                        nx = x + dx;
                        ny = y + dy;
                        nz = z + dz;
                        if (dx == 0 && dy == 0 && dz == 0) continue;
                        if (nx < 0 || ny < 0 || nz < 0 || nx >= w || ny >= h || nz >= d)
                            bnd = 1;
                        else if (vox_labels[nz * plane + ny * w + nx] != cur)
                            bnd = 1;
                    end
        end
        r.x = x[6:0];
        r.y = y[6:0];
        r.z = z[11:0];
        r.lbl = cur;
        r.bnd = bnd;
        r.sel = bnd && (cur == target_reg);
        r.last = (out_pos + 1 == total);
        rpt_q.push_back(r);
        out_pos++;
    endtask

    always @(posedge i_clk) begin
        t_voxel_rpt want, got;
        if (!i_rst_n) begin
            width_reg  = 8'd128;
            height_reg = 8'd128;
            depth_reg  = 13'd128;
            target_reg = 32'd1;
            null_reg   = 32'd0;
            in_pos     = 0;
            out_pos    = 0;
            errors     = 0;
            checked    = 0;
            rpt_q.delete();
            pend       = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    vbe_pkg::REG_VOL_WIDTH:    width_reg  = i_cfg_data[7:0];
                    vbe_pkg::REG_VOL_HEIGHT:   height_reg = i_cfg_data[7:0];
                    vbe_pkg::REG_VOL_DEPTH:    depth_reg  = i_cfg_data[12:0];
                    vbe_pkg::REG_TARGET_LABEL: target_reg = i_cfg_data;
                    vbe_pkg::REG_NULL_LABEL:   null_reg   = i_cfg_data;
                    default: ;
                endcase
                if (i_cfg_index <= vbe_pkg::REG_NULL_LABEL) begin
                    in_pos  = 0;
                    out_pos = 0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.x = i_m_tdata[6:0];
                got.y = i_m_tdata[13:7];
                got.z = i_m_tdata[25:14];
                got.lbl = i_m_tdata[57:26];
                got.bnd = i_m_tuser[0];
                got.sel = i_m_tuser[1];
                got.last = i_m_tlast;
                checked++;
                if (rpt_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected report x=%0d y=%0d z=%0d label=%h",
                                 got.x, got.y, got.z, got.lbl);
                end else begin
                    want = rpt_q.pop_front();
                    if (got != want || i_m_tdata[63:58] != 6'd0) begin
                        errors++;
                        if (errors <= 10)
                            $display({"ERROR: report mismatch exp x=%0d y=%0d z=%0d ",
                                      "lbl=%h b=%0d s=%0d l=%0d | got x=%0d y=%0d ",
                                      "z=%0d lbl=%h b=%0d s=%0d l=%0d pad=%h"},
                                     want.x, want.y, want.z, want.lbl, want.bnd,
                                     want.sel, want.last, got.x, got.y, got.z,
                                     got.lbl, got.bnd, got.sel, got.last,
                                     i_m_tdata[63:58]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                advance_window(i_s_tuser, i_s_tdata);
            pend = rpt_q.size();
        end
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    wire logic        cfg_ready, s_tready, m_tvalid, m_tlast;
    wire logic [63:0] m_tdata;
    wire logic [1:0]  m_tuser;
    int errors, pending, checked;

    int items_sent = 0;
    int burst_left = 0;
    int volumes = 0;
    logic [31:0] cur_target, cur_null;

    voxel_boundary_extract_3d dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast)
    );

    boundary_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: stall pattern changes mode now and then (always ready, light,
    // heavy). Once, after a few hundred items, a long hold-off backs the
    // pipeline up into the input side.
    int  hold_left = 0;
    bit  hold_done = 0;
    int  mode_left = 0;
    int  ready_pct = 100;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (!hold_done && items_sent >= 200) begin
            hold_done = 1;
            hold_left = 600;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                mode_left = $urandom_range(20, 200);
                case ($urandom_range(0, 2))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    default: ready_pct = 25;
                endcase
            end
            mode_left--;
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    function automatic int clamp_dim(int v, int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Sender: bursts of back-to-back transfers separated by random gaps.
    task automatic send_item(bit flush, logic [31:0] lbl);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= flush;
        s_tdata  <= lbl;
        @(negedge i_clk);
        while (!s_tready) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
    endtask

    // cfg_valid is left high so back-to-back writes need one assignment per step
    task automatic write_reg(vbe_pkg::t_cfg_idx idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        while (!cfg_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_volume(int w, int h, int d, logic [31:0] tgt, logic [31:0] nul);
        write_reg(vbe_pkg::REG_VOL_WIDTH, w);
        write_reg(vbe_pkg::REG_VOL_HEIGHT, h);
        write_reg(vbe_pkg::REG_VOL_DEPTH, d);
        write_reg(vbe_pkg::REG_TARGET_LABEL, tgt);
        write_reg(vbe_pkg::REG_NULL_LABEL, nul);
        cfg_valid <= 1'b0;
        cur_target = tgt;
        cur_null = nul;
    endtask

    // Let every expected report come out, then let the internal drain settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Blocky label field: mostly runs of the same label, drawn from a small
    // pool (null, target, two others) so interiors and edges both show up.
    task automatic run_volume(int w_raw, int h_raw, int d_raw, int noise_pct);
        int w, h, d, total, lag, released, drain;
        logic [31:0] pool[4];
        logic [31:0] lbl;
        w = clamp_dim(w_raw, 128);
        h = clamp_dim(h_raw, 128);
        d = clamp_dim(d_raw, vbe_pkg::DEPTH_LIMIT);
        total = w * h * d;
        lag = w * h + w + 1;
        pool[0] = cur_null;
        pool[1] = cur_target;
        pool[2] = $urandom;
        pool[3] = $urandom;
        lbl = pool[$urandom_range(0, 3)];
        for (int i = 0; i < total; i++) begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_item(1'b1, $urandom);   // flush mid-volume: no effect
            if ($urandom_range(1, 100) <= 3)
                lbl = $urandom;
            else if ($urandom_range(1, 100) > 60)
                lbl = pool[$urandom_range(0, 3)];
            send_item(1'b0, lbl);
        end
        // reports still held back after the last voxel
        released = ((total - 1 > lag) ? total - 1 - lag : 0) + 1;
        drain = total - released;
        for (int i = 0; i < drain; i++) begin
            // a surplus voxel acts as a flush and its label is dropped
            if ($urandom_range(1, 100) <= 30)
                send_item(1'b0, $urandom);
            else
                send_item(1'b1, $urandom);
        end
        // an idle flush restarts the positions but produces nothing
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_item(1'b1, $urandom);
        volumes++;
    endtask

    initial begin
        int w, h, d;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single voxel volume: always on the boundary, selected, last
        set_volume(1, 1, 1, 32'h0000_0005, 32'h0000_0000);
        send_item(1'b0, 32'h0000_0005);
        send_item(1'b1, 32'hFFFF_FFFF);   // idle flush
        send_item(1'b0, 32'h0000_0000);   // null voxel, never boundary
        wait_idle();
        // zero dimensions clamp to one; all-ones null and target
        set_volume(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(1'b0, 32'hFFFF_FFFF);
        send_item(1'b0, 32'h0000_0000);
        wait_idle();
        // 2x1x2 volume of one label, drained by flushes
        set_volume(2, 1, 2, 32'h0000_0007, 32'h0000_0000);
        repeat (4) send_item(1'b0, 32'h0000_0007);
        repeat (3) send_item(1'b1, 32'h0000_0000);
        wait_idle();

        // extremes: widest row (clamped), tallest plane, a deeper thin column
        set_volume(255, 1, 1, $urandom, 32'h0000_0000);
        run_volume(255, 1, 1, 0);
        wait_idle();
        set_volume(1, 128, 1, $urandom, $urandom);
        run_volume(1, 128, 1, 0);
        wait_idle();
        set_volume(3, 10, 3, $urandom, $urandom);
        run_volume(3, 10, 3, 0);
        wait_idle();
        set_volume(1, 1, 40, $urandom, 32'h0000_0000);
        run_volume(1, 1, 40, 0);
        wait_idle();

        // random small volumes, sometimes two back to back on one setting
        while (items_sent < 800) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 6);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 6);
            d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : $urandom_range(1, 5);
            set_volume(w, h, d, $urandom,
                       ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : $urandom);
            run_volume(w, h, d, 8);
            if ($urandom_range(0, 2) == 0)
                run_volume(w, h, d, 8);
            wait_idle();
        end

        $display("Summary: %0d items sent over %0d volumes, %0d voxel reports checked",
                 items_sent, volumes, checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5ms;
        $display("Timeout waiting for voxel reports");
        $display("DONE: errors detected");
        $finish;
    end

endmodule
